[hdl/shuffle_play_order_queue_macros.svh]
// assertion macros for the play-order queue
`ifndef SHUFFLE_PLAY_ORDER_QUEUE_MACROS_SVH
`define SHUFFLE_PLAY_ORDER_QUEUE_MACROS_SVH

// implication checked at every clock edge outside reset
`define SPOQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// plain invariant checked at every clock edge outside reset
`define SPOQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

[hdl/spoq_pkg.sv]
package spoq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 64;
    localparam int HISTORY_DEPTH_DEF = 64;

    localparam int CMD_W    = 3;
    localparam int LEN_W    = 7;
    localparam int POS_W    = 7;
    localparam int RND_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CURPOS_W = 6;

    localparam int IN_BITS   = CMD_W + LEN_W + POS_W + 1 + RND_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = STATUS_W + 1 + CURPOS_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD     = 3'd0,
        CMD_SELECT   = 3'd1,
        CMD_NEXT     = 3'd2,
        CMD_PREVIOUS = 3'd3,
        CMD_SHUFFLE  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_BOUNDARY = 2'd2
    } status_t;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_REFILL  = 10'b00_0000_0010,
        S_DIV     = 10'b00_0000_0100,
        S_PICK_RD = 10'b00_0000_1000,
        S_PICK_WR = 10'b00_0001_0000,
        S_SH_RD   = 10'b00_0010_0000,
        S_SH_WR   = 10'b00_0100_0000,
        S_POP_RD  = 10'b00_1000_0000,
        S_POP_WR  = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } state_t;

endpackage

[hdl/shuffle_play_order_queue.sv]
// play-order engine over the positions of a play queue
// input channel s_*: one command item (load, select, next, previous, set shuffle)
// output channel m_*: exactly one result item per command (status, current
// position, shuffle flag)
// one command at a time: s_tready is high only while the sequencer is idle and
// no result is waiting, so the next command waits until m_tready takes the result
// simple commands go straight to the result; previous in shuffle puts the current
// position back into the pool when there is room and reads the prior one from the
// history; load, select and set shuffle add a pool refill over all entries;
// shuffled next runs the modulo (one quotient bit a cycle), then the pick read,
// then moves each later pool entry down one place during compaction, with a
// refill first when the pool ran dry; pool and history sit in single-port-write
// memories with registered reads, so each compaction step has a read and a write state
// reset clears all counters and flags; memory contents are not cleared and
// are only read below their counts
// when the receiver stalls the result holds on m_tdata and no command is taken
`include "shuffle_play_order_queue_macros.svh"

module shuffle_play_order_queue
    import spoq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // command, list_length, position, enable, random_value
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status, has_current, current_position, shuffle_active
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int IW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int HW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HCW   = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 2;
    localparam int PW    = (IW > CURPOS_W) ? IW : CURPOS_W;
    localparam int DCW   = $clog2(RND_W);

    logic [CMD_W-1:0] in_cmd;
    logic [LEN_W-1:0] in_len;
    logic [POS_W-1:0] in_pos;
    logic             in_en;
    logic [RND_W-1:0] in_rnd;

    assign in_cmd = s_tdata[CMD_W-1:0];
    assign in_len = s_tdata[CMD_W +: LEN_W];
    assign in_pos = s_tdata[CMD_W+LEN_W +: POS_W];
    assign in_en  = s_tdata[CMD_W+LEN_W+POS_W];
    assign in_rnd = s_tdata[CMD_W+LEN_W+POS_W+1 +: RND_W];

    state_t state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [CW-1:0] entry_reg, entry_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic cur_valid_reg, cur_valid_next;
    logic shuffle_reg, shuffle_next;
    logic [HW-1:0] htop_reg, htop_next;
    logic [HCW-1:0] hcount_reg, hcount_next;
    logic [CW-1:0] pcount_reg, pcount_next;
    logic [CW-1:0] ref_i_reg, ref_i_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic m_tvalid_reg, m_tvalid_next;

    logic [IW-1:0] pool_mem [QUEUE_DEPTH];
    logic [IW-1:0] hist_mem [HISTORY_DEPTH];
    logic          pool_we, hist_we;
    logic [IW-1:0] pool_waddr, pool_wdata, pool_raddr, pool_q;
    logic [HW-1:0] hist_waddr, hist_raddr;
    logic [IW-1:0] hist_wdata, hist_q;

    logic [CMP_W-1:0] len_x, pos_x, entry_x, cur_x, pcount_x, idx_x, ref_x;
    logic [CW:0]      div_shift;
    logic [CW:0]      div_d;
    logic [CW-1:0]    len_sat;
    logic [HW-1:0]    htop_inc, htop_dec;
    logic [PW-1:0]    cur_out;

    assign len_x    = CMP_W'(in_len);
    assign pos_x    = CMP_W'(in_pos);
    assign entry_x  = CMP_W'(entry_reg);
    assign cur_x    = CMP_W'(cur_reg);
    assign pcount_x = CMP_W'(pcount_reg);
    assign idx_x    = CMP_W'(idx_reg);
    assign ref_x    = CMP_W'(ref_i_reg);
    assign len_sat  = (len_x > CMP_W'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(in_len);
    assign htop_inc = (htop_reg == HW'(HISTORY_DEPTH - 1)) ? '0 : htop_reg + 1'b1;
    assign htop_dec = (htop_reg == '0) ? HW'(HISTORY_DEPTH - 1) : htop_reg - 1'b1;
    assign div_shift = {rem_reg, rnd_reg[RND_W-1]};
    assign div_d     = {1'b0, pcount_reg};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        entry_next     = entry_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        shuffle_next   = shuffle_reg;
        htop_next      = htop_reg;
        hcount_next    = hcount_reg;
        pcount_next    = pcount_reg;
        ref_i_next     = ref_i_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        rnd_next       = rnd_reg;
        dcnt_next      = dcnt_reg;
        status_next    = status_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        pool_we        = 1'b0;
        pool_waddr     = pcount_reg[IW-1:0];
        pool_wdata     = ref_i_reg[IW-1:0];
        pool_raddr     = idx_reg;
        hist_we        = 1'b0;
        hist_waddr     = htop_reg;
        hist_wdata     = cur_reg;
        hist_raddr     = htop_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd_next    = in_cmd;
                    rnd_next    = in_rnd;
                    status_next = ST_OK;
                    ref_i_next  = '0;
                    state_next  = S_DONE;
                    case (in_cmd)
                        CMD_LOAD:
                        begin
                            entry_next     = len_sat;
                            cur_valid_next = (len_sat != '0);
                            cur_next       = (pos_x < CMP_W'(len_sat)) ? IW'(in_pos) : '0;
                            htop_next      = '0;
                            hcount_next    = '0;
                            pcount_next    = '0;
                            state_next     = S_REFILL;
                        end
                        CMD_SELECT:
                        begin
                            if (pos_x >= entry_x)
                            begin
                                status_next = ST_INVALID;
                            end
                            else
                            begin
                                cur_next       = IW'(in_pos);
                                cur_valid_next = 1'b1;
                                htop_next      = '0;
                                hcount_next    = '0;
                                pcount_next    = '0;
                                state_next     = S_REFILL;
                            end
                        end
                        CMD_NEXT:
                        begin
                            if (!cur_valid_reg)
                            begin
                                status_next = ST_INVALID;
                            end
                            else if (shuffle_reg)
                            begin
                                rem_next  = '0;
                                dcnt_next = '0;
                                if (pcount_reg == '0)
                                begin
                                    state_next = S_REFILL;
                                end
                                else
                                begin
                                    state_next = S_DIV;
                                end
                            end
                            else if (cur_x + 1'b1 >= entry_x)
                            begin
                                status_next = ST_BOUNDARY;
                            end
                            else
                            begin
                                cur_next = cur_reg + 1'b1;
                            end
                        end
                        CMD_PREVIOUS:
                        begin
                            if (!cur_valid_reg)
                            begin
                                status_next = ST_INVALID;
                            end
                            else if (shuffle_reg)
                            begin
                                if (hcount_reg == '0)
                                begin
                                    status_next = ST_BOUNDARY;
                                end
                                else
                                begin
                                    if (pcount_x < CMP_W'(QUEUE_DEPTH))
                                    begin
                                        pool_we     = 1'b1;
                                        pool_wdata  = cur_reg;
                                        pcount_next = pcount_reg + 1'b1;
                                    end
                                    htop_next   = htop_dec;
                                    hcount_next = hcount_reg - 1'b1;
                                    state_next  = S_POP_RD;
                                end
                            end
                            else if (cur_reg == '0)
                            begin
                                status_next = ST_BOUNDARY;
                            end
                            else
                            begin
                                cur_next = cur_reg - 1'b1;
                            end
                        end
                        CMD_SHUFFLE:
                        begin
                            shuffle_next = in_en && (entry_x > CMP_W'(1));
                            htop_next    = '0;
                            hcount_next  = '0;
                            pcount_next  = '0;
                            state_next   = S_REFILL;
                        end
                        default:
                        begin
                            status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_REFILL:
            begin
                if (ref_i_reg == entry_reg)
                begin
                    if (cmd_reg != CMD_NEXT)
                    begin
                        state_next = S_DONE;
                    end
                    else if (pcount_reg == '0)
                    begin
                        status_next = ST_BOUNDARY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    if (!(cur_valid_reg && ref_x == cur_x))
                    begin
                        pool_we     = 1'b1;
                        pcount_next = pcount_reg + 1'b1;
                    end
                    ref_i_next = ref_i_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_shift >= div_d)
                begin
                    rem_next = CW'(div_shift - div_d);
                end
                else
                begin
                    rem_next = CW'(div_shift);
                end
                rnd_next  = {rnd_reg[RND_W-2:0], 1'b0};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(RND_W - 1))
                begin
                    state_next = S_PICK_RD;
                end
            end
            S_PICK_RD:
            begin
                idx_next   = rem_reg[IW-1:0];
                pool_raddr = rem_reg[IW-1:0];
                state_next = S_PICK_WR;
            end
            S_PICK_WR:
            begin
                hist_we  = 1'b1;
                cur_next = pool_q;
                htop_next = htop_inc;
                if (hcount_reg != HCW'(HISTORY_DEPTH))
                begin
                    hcount_next = hcount_reg + 1'b1;
                end
                if (idx_x + 1'b1 < pcount_x)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    pcount_next = pcount_reg - 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_SH_RD:
            begin
                pool_raddr = idx_reg + 1'b1;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                pool_we    = 1'b1;
                pool_waddr = idx_reg;
                pool_wdata = pool_q;
                idx_next   = idx_reg + 1'b1;
                if (idx_x + CMP_W'(2) < pcount_x)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    pcount_next = pcount_reg - 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_POP_RD:
            begin
                state_next = S_POP_WR;
            end
            S_POP_WR:
            begin
                cur_next   = hist_q;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                m_tvalid_next = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            entry_reg     <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            shuffle_reg   <= 1'b0;
            htop_reg      <= '0;
            hcount_reg    <= '0;
            pcount_reg    <= '0;
            ref_i_reg     <= '0;
            idx_reg       <= '0;
            dcnt_reg      <= '0;
            status_reg    <= ST_OK;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            entry_reg     <= entry_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            shuffle_reg   <= shuffle_next;
            htop_reg      <= htop_next;
            hcount_reg    <= hcount_next;
            pcount_reg    <= pcount_next;
            ref_i_reg     <= ref_i_next;
            idx_reg       <= idx_next;
            dcnt_reg      <= dcnt_next;
            status_reg    <= status_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        rnd_reg <= rnd_next;
    end

    // pool and history memories, registered read
    always_ff @(posedge clk)
    begin
        if (pool_we)
        begin
            pool_mem[pool_waddr] <= pool_wdata;
        end
        pool_q <= pool_mem[pool_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_q <= hist_mem[hist_raddr];
    end

    assign s_tready = (state_reg == S_IDLE) && !m_tvalid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign cur_out  = cur_valid_reg ? PW'(cur_reg) : '0;
    assign m_tdata  = OUT_DATA_W'({shuffle_reg, cur_out[CURPOS_W-1:0],
                                   cur_valid_reg, status_reg});

    `SPOQ_ASSERT_IMPL(a_ready_only_idle, clk, rst_n, s_tready, (state_reg == S_IDLE) && !m_tvalid_reg, "ready outside idle")
    `SPOQ_ASSERT_ALWAYS(a_pool_bound, clk, rst_n, CMP_W'(pcount_reg) <= CMP_W'(QUEUE_DEPTH), "pool count overflow")
    `SPOQ_ASSERT_ALWAYS(a_hist_bound, clk, rst_n, hcount_reg <= HCW'(HISTORY_DEPTH), "history count overflow")
    `SPOQ_ASSERT_IMPL(a_cur_in_range, clk, rst_n, cur_valid_reg && (state_reg == S_IDLE), cur_x < entry_x, "current beyond length")

endmodule
